@@ hw/rtl/emcc_pkg.sv @@
// shared types, constants and calendar helpers for the elapsed-ms calendar clock
package emcc_pkg;

	localparam int STAMP_W     = 32;
	localparam int SEC_W       = 6;
	localparam int MIN_W       = 6;
	localparam int HOUR_W      = 5;
	localparam int DAY_W       = 5;
	localparam int MONTH_W     = 4;
	localparam int YEAR_W      = 6;
	localparam int FULL_YEAR_W = 16;
	localparam int DAYS_W      = 6;

	localparam int MS_PER_SEC   = 1000;
	localparam int SEC_PER_MIN  = 60;
	localparam int MIN_PER_HOUR = 60;
	localparam int HOUR_PER_DAY = 24;

	localparam int MAX_DAYS_PER_STAMP = 49;
	localparam int MAX_MONTH_DAYS     = 31;

	localparam logic [FULL_YEAR_W-1:0] BASE_YEAR_RESET = 16'd2000;
	localparam int                     YEAR_WRAP       = 64;
	localparam logic [YEAR_W-1:0]      YEAR_MAX        = 6'd63;

	localparam int YEAR_CYCLE = 400;
	localparam int CENTURY    = 100;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	typedef struct packed {
		logic              is_set;
		logic [SEC_W-1:0]  sec;
		logic [MIN_W-1:0]  min;
		logic [HOUR_W-1:0] hour;
		logic [DAYS_W-1:0] day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0] year;
	} cmd_t;

	function automatic logic is_leap(input logic [FULL_YEAR_W-1:0] year);
		logic [16:0] r;
		logic [16:0] m;
		r = 17'(year);
		for (int k = 7; k >= 0; k--) begin
			m = 17'(YEAR_CYCLE) << k;
			if (r >= m) begin
				r = r - m;
			end
		end
		return (r == 17'd0) ||
			((r[1:0] == 2'b00) && (r != 17'(CENTURY)) && (r != 17'(2 * CENTURY)) &&
			(r != 17'(3 * CENTURY)));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] n;
		case (month) inside
			MONTH_FEB: n = leap ? 5'd29 : 5'd28;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			default: n = 5'd30;
		endcase
		return n;
	endfunction

endpackage

@@ hw/rtl/emcc_if.sv @@
// valid/ready channel interfaces for items, results and the base year write port
interface emcc_item_if import emcc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [STAMP_W-1:0]   now_ms;
	logic [SEC_W-1:0]     set_second;
	logic [MIN_W-1:0]     set_minute;
	logic [HOUR_W-1:0]    set_hour;
	logic [DAY_W-1:0]     set_day;
	logic [MONTH_W-1:0]   set_month;
	logic [YEAR_W-1:0]    set_year;

	modport source (output valid, kind, now_ms, set_second, set_minute, set_hour, set_day,
		set_month, set_year, input ready);
	modport sink (input valid, kind, now_ms, set_second, set_minute, set_hour, set_day,
		set_month, set_year, output ready);
endinterface

interface emcc_result_if import emcc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SEC_W-1:0]       second;
	logic [MIN_W-1:0]       minute;
	logic [HOUR_W-1:0]      hour;
	logic [DAY_W-1:0]       day;
	logic [MONTH_W-1:0]     month;
	logic [YEAR_W-1:0]      year_offset;
	logic [FULL_YEAR_W-1:0] full_year;

	modport source (output valid, second, minute, hour, day, month, year_offset, full_year,
		input ready);
	modport sink (input valid, second, minute, hour, day, month, year_offset, full_year,
		output ready);
endinterface

interface emcc_cfg_if import emcc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [FULL_YEAR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/emcc_queue.sv @@
// two-entry command queue between the front and back parts
module emcc_queue import emcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

@@ hw/rtl/emcc_front.sv @@
// front part: takes items, splits elapsed time into seconds, minutes, hours and days
module emcc_front import emcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	emcc_item_if.sink   item,
	output logic        push_valid,
	input  logic        push_ready,
	output cmd_t        push_cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	localparam logic [1:0] DIV_MS   = 2'd0;
	localparam logic [1:0] DIV_SEC  = 2'd1;
	localparam logic [1:0] DIV_MIN  = 2'd2;
	localparam logic [1:0] DIV_HOUR = 2'd3;

	localparam int STEPS_MS   = 16;
	localparam int STEPS_SEC  = 12;
	localparam int STEPS_MIN  = 9;
	localparam int STEPS_HOUR = 6;

	logic [1:0]         state_q;
	logic [1:0]         stage_q;
	logic [3:0]         step_q;
	logic [STAMP_W-1:0] last_q;
	logic [STAMP_W-1:0] quo_q;
	logic [9:0]         rem_q;
	cmd_t               cmd_q;

	logic [11:0]        divisor;
	logic [11:0]        div2;
	logic [11:0]        div3;
	logic [11:0]        trial;
	logic [1:0]         digit;
	logic [9:0]         rem_next;
	logic [STAMP_W-1:0] quo_next;

	assign item.ready = (state_q == ST_IDLE);
	assign push_valid = (state_q == ST_PUSH);
	assign push_cmd   = cmd_q;

	// radix-4 restoring step by a constant divisor
	always_comb begin
		unique case (stage_q)
			DIV_MS:  divisor = 12'(MS_PER_SEC);
			DIV_SEC: divisor = 12'(SEC_PER_MIN);
			DIV_MIN: divisor = 12'(MIN_PER_HOUR);
			default: divisor = 12'(HOUR_PER_DAY);
		endcase
		div2  = {divisor[10:0], 1'b0};
		div3  = div2 + divisor;
		trial = {rem_q, quo_q[STAMP_W-1 -: 2]};
		if (trial >= div3) begin
			digit    = 2'd3;
			rem_next = 10'(trial - div3);
		end else if (trial >= div2) begin
			digit    = 2'd2;
			rem_next = 10'(trial - div2);
		end else if (trial >= divisor) begin
			digit    = 2'd1;
			rem_next = 10'(trial - divisor);
		end else begin
			digit    = 2'd0;
			rem_next = trial[9:0];
		end
		quo_next = {quo_q[STAMP_W-3:0], digit};
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					if (item.kind) begin
						cmd_q.is_set <= 1'b1;
						cmd_q.sec    <= item.set_second;
						cmd_q.min    <= item.set_minute;
						cmd_q.hour   <= item.set_hour;
						cmd_q.day    <= DAYS_W'(item.set_day);
						cmd_q.month  <= item.set_month;
						cmd_q.year   <= item.set_year;
					end else begin
						cmd_q.is_set <= 1'b0;
						cmd_q.month  <= '0;
						cmd_q.year   <= '0;
						quo_q        <= item.now_ms - last_q;
						rem_q        <= '0;
					end
				end
			end
			ST_DIV: begin
				if (step_q != '0) begin
					quo_q <= quo_next;
					rem_q <= rem_next;
				end else begin
					rem_q <= '0;
					unique case (stage_q)
						DIV_MS: begin
							quo_q <= quo_next << (STAMP_W - 2 * STEPS_SEC);
						end
						DIV_SEC: begin
							cmd_q.sec <= rem_next[SEC_W-1:0];
							quo_q     <= quo_next << (STAMP_W - 2 * STEPS_MIN);
						end
						DIV_MIN: begin
							cmd_q.min <= rem_next[MIN_W-1:0];
							quo_q     <= quo_next << (STAMP_W - 2 * STEPS_HOUR);
						end
						default: begin
							cmd_q.hour <= rem_next[HOUR_W-1:0];
							cmd_q.day  <= quo_next[DAYS_W-1:0];
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_q <= DIV_MS;
			step_q  <= '0;
			last_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						if (item.kind) begin
							state_q <= ST_PUSH;
						end else begin
							last_q  <= item.now_ms;
							stage_q <= DIV_MS;
							step_q  <= 4'(STEPS_MS - 1);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (step_q != '0) begin
						step_q <= step_q - 4'd1;
					end else begin
						unique case (stage_q)
							DIV_MS: begin
								stage_q <= DIV_SEC;
								step_q  <= 4'(STEPS_SEC - 1);
							end
							DIV_SEC: begin
								stage_q <= DIV_MIN;
								step_q  <= 4'(STEPS_MIN - 1);
							end
							DIV_MIN: begin
								stage_q <= DIV_HOUR;
								step_q  <= 4'(STEPS_HOUR - 1);
							end
							default: begin
								state_q <= ST_PUSH;
							end
						endcase
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (12'(rem_q) < divisor))
		else $error("divider remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !cmd_q.is_set) |->
		((cmd_q.sec < SEC_W'(SEC_PER_MIN)) && (cmd_q.min < MIN_W'(MIN_PER_HOUR)) &&
		(cmd_q.hour < HOUR_W'(HOUR_PER_DAY)) && (cmd_q.day <= DAYS_W'(MAX_DAYS_PER_STAMP))))
		else $error("elapsed time split out of range");

endmodule

@@ hw/rtl/emcc_back.sv @@
// back part: calendar state, carry sequencing, month walk and result register
module emcc_back import emcc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	emcc_cfg_if.sink       cfg,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  cmd_t           pop_cmd,
	emcc_result_if.source  result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_NEXT  = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_DLEN  = 3'd3;
	localparam logic [2:0] ST_DSTEP = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [2:0] PART_SEC  = 3'd0;
	localparam logic [2:0] PART_MIN  = 3'd1;
	localparam logic [2:0] PART_HOUR = 3'd2;
	localparam logic [2:0] PART_DAY  = 3'd3;
	localparam logic [2:0] PART_DONE = 3'd4;

	localparam logic [1:0] UNIT_SEC  = 2'd0;
	localparam logic [1:0] UNIT_MIN  = 2'd1;
	localparam logic [1:0] UNIT_HOUR = 2'd2;

	logic [2:0]             state_q;
	logic [2:0]             part_q;
	logic [1:0]             unit_q;
	logic [DAYS_W-1:0]      amt_q;
	logic [6:0]             d_q;
	logic [DAY_W-1:0]       len_q;
	cmd_t                   cmd_q;

	logic [SEC_W-1:0]       cur_sec_q;
	logic [MIN_W-1:0]       cur_min_q;
	logic [HOUR_W-1:0]      cur_hour_q;
	logic [DAY_W-1:0]       cur_day_q;
	logic [MONTH_W-1:0]     cur_month_q;
	logic [YEAR_W-1:0]      cur_year_q;
	logic [FULL_YEAR_W-1:0] year_base_q;

	logic                   res_valid_q;
	logic [SEC_W-1:0]       res_sec_q;
	logic [MIN_W-1:0]       res_min_q;
	logic [HOUR_W-1:0]      res_hour_q;
	logic [DAY_W-1:0]       res_day_q;
	logic [MONTH_W-1:0]     res_month_q;
	logic [YEAR_W-1:0]      res_year_q;
	logic [FULL_YEAR_W-1:0] res_full_q;

	logic [6:0]             add_cur;
	logic [6:0]             add_lim;
	logic [6:0]             add_sum;
	logic [6:0]             add_res;
	logic                   add_carry;
	logic                   out_load;

	assign pop_ready          = (state_q == ST_IDLE);
	assign cfg.ready          = 1'b1;
	assign out_load           = (state_q == ST_OUT) && (!res_valid_q || result.ready);
	assign result.valid       = res_valid_q;
	assign result.second      = res_sec_q;
	assign result.minute      = res_min_q;
	assign result.hour        = res_hour_q;
	assign result.day         = res_day_q;
	assign result.month       = res_month_q;
	assign result.year_offset = res_year_q;
	assign result.full_year   = res_full_q;

	// one unit add with a single carry out
	always_comb begin
		unique case (unit_q)
			UNIT_SEC: begin
				add_cur = 7'(cur_sec_q);
				add_lim = 7'(SEC_PER_MIN);
			end
			UNIT_MIN: begin
				add_cur = 7'(cur_min_q);
				add_lim = 7'(MIN_PER_HOUR);
			end
			default: begin
				add_cur = 7'(cur_hour_q);
				add_lim = 7'(HOUR_PER_DAY);
			end
		endcase
		add_sum   = add_cur + 7'(amt_q);
		add_carry = (add_sum >= add_lim);
		add_res   = add_carry ? (add_sum - add_lim) : add_sum;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			cmd_q <= pop_cmd;
		end
		if (out_load) begin
			res_sec_q   <= cur_sec_q;
			res_min_q   <= cur_min_q;
			res_hour_q  <= cur_hour_q;
			res_day_q   <= cur_day_q;
			res_month_q <= cur_month_q;
			res_year_q  <= cur_year_q;
			res_full_q  <= year_base_q + FULL_YEAR_W'(cur_year_q);
		end
		unique case (state_q)
			ST_NEXT: begin
				unique case (part_q)
					PART_SEC:  amt_q <= cmd_q.sec;
					PART_MIN:  amt_q <= cmd_q.min;
					PART_HOUR: amt_q <= DAYS_W'(cmd_q.hour);
					PART_DAY:  d_q   <= 7'(cur_day_q) + 7'(cmd_q.day);
					default: begin
					end
				endcase
			end
			ST_ADD: begin
				if (add_carry) begin
					amt_q <= DAYS_W'(1);
					d_q   <= 7'(cur_day_q) + 7'd1;
				end
			end
			ST_DLEN: begin
				len_q <= month_days(cur_month_q,
					is_leap(year_base_q + FULL_YEAR_W'(cur_year_q)));
			end
			ST_DSTEP: begin
				if (d_q > 7'(len_q)) begin
					d_q <= d_q - 7'(len_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			part_q      <= PART_SEC;
			unit_q      <= UNIT_SEC;
			cur_sec_q   <= '0;
			cur_min_q   <= '0;
			cur_hour_q  <= '0;
			cur_day_q   <= DAY_W'(1);
			cur_month_q <= MONTH_JAN;
			cur_year_q  <= '0;
			year_base_q <= BASE_YEAR_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						if (pop_cmd.is_set) begin
							cur_sec_q   <= pop_cmd.sec;
							cur_min_q   <= pop_cmd.min;
							cur_hour_q  <= pop_cmd.hour;
							cur_day_q   <= pop_cmd.day[DAY_W-1:0];
							cur_month_q <= pop_cmd.month;
							cur_year_q  <= pop_cmd.year;
							state_q     <= ST_OUT;
						end else begin
							part_q  <= PART_SEC;
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					unique case (part_q)
						PART_SEC: begin
							part_q <= PART_MIN;
							unit_q <= UNIT_SEC;
							if (cmd_q.sec != '0) begin
								state_q <= ST_ADD;
							end
						end
						PART_MIN: begin
							part_q <= PART_HOUR;
							unit_q <= UNIT_MIN;
							if (cmd_q.min != '0) begin
								state_q <= ST_ADD;
							end
						end
						PART_HOUR: begin
							part_q <= PART_DAY;
							unit_q <= UNIT_HOUR;
							if (cmd_q.hour != '0) begin
								state_q <= ST_ADD;
							end
						end
						PART_DAY: begin
							part_q <= PART_DONE;
							if (cmd_q.day != '0) begin
								state_q <= ST_DLEN;
							end
						end
						default: begin
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_ADD: begin
					unique case (unit_q)
						UNIT_SEC: cur_sec_q <= add_res[SEC_W-1:0];
						UNIT_MIN: cur_min_q <= add_res[MIN_W-1:0];
						default:  cur_hour_q <= add_res[HOUR_W-1:0];
					endcase
					if (!add_carry) begin
						state_q <= ST_NEXT;
					end else if (unit_q == UNIT_HOUR) begin
						state_q <= ST_DLEN;
					end else begin
						unit_q <= unit_q + 2'd1;
					end
				end
				ST_DLEN: begin
					state_q <= ST_DSTEP;
				end
				ST_DSTEP: begin
					if (d_q > 7'(len_q)) begin
						if (cur_month_q == MONTH_DEC) begin
							cur_month_q <= MONTH_JAN;
							if (cur_year_q == YEAR_MAX) begin
								cur_year_q  <= '0;
								year_base_q <= year_base_q + FULL_YEAR_W'(YEAR_WRAP);
							end else begin
								cur_year_q <= cur_year_q + 6'd1;
							end
						end else begin
							cur_month_q <= cur_month_q + 4'd1;
						end
						state_q <= ST_DLEN;
					end else begin
						cur_day_q <= d_q[DAY_W-1:0];
						state_q   <= ST_NEXT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg.valid) begin
				year_base_q <= cfg.data;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DSTEP) |-> ((len_q >= 5'd28) && (len_q <= 5'd31)))
		else $error("month length out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> (7'(amt_q) < add_lim))
		else $error("unit add amount not below unit limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DLEN) || (state_q == ST_DSTEP)) |->
		(d_q <= 7'(MAX_MONTH_DAYS + MAX_DAYS_PER_STAMP)))
		else $error("pending day count out of range");

endmodule

@@ hw/rtl/elapsed_ms_calendar_clock_core.sv @@
// a set item loads the calendar state and goes to the result register; a timestamp item
// passes the shared radix-4 divider (by 1000, 60, 60, 24), then each nonzero unit add or carry
// and, per month crossed, a month length lookup and a day step; front and back overlap
// throughput: one timestamp item per divider pass while the 2-entry queue between them has room
// reset: arst_n clears the clock to 00:00:00, day 1, month 1, offset 0, base year 2000
module elapsed_ms_calendar_clock_core import emcc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	emcc_item_if.sink     item,
	emcc_result_if.source result,
	emcc_cfg_if.sink      cfg
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	emcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	emcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	emcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.result    (result)
	);

endmodule
